// ----- rtl/nps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

  localparam int unsigned WindowBytes = 7;
  localparam int unsigned FillW       = $clog2(WindowBytes + 1);
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QPtrW       = $clog2(QueueDepth);
  localparam int unsigned QCountW     = $clog2(QueueDepth + 1);

  localparam logic [7:0] ZeroByte    = 8'h00;
  localparam logic [7:0] OneByte     = 8'h01;
  localparam logic [7:0] NalTypeMask = 8'h7E;

  localparam logic [5:0] NalTypeSplit  = 6'd1;
  localparam logic [5:0] NalTypeIdrLp  = 6'd19;
  localparam logic [5:0] NalTypeVps    = 6'd32;
  localparam logic [5:0] NalTypeSps    = 6'd33;
  localparam logic [5:0] NalTypePps    = 6'd34;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_packet;
    logic       key_frame;
    logic       first_of_unit;
  } nps_beat_t;

  function automatic logic is_key_type(input logic [5:0] t);
    return (t inside {NalTypeIdrLp, NalTypeVps, NalTypeSps, NalTypePps});
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hevc_nal_packet_splitter.sv -----
// channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+------------------------------------
// in       | input     | in_valid_i / in_stall_o      | data_byte_i[7:0]
// out      | output    | out_valid_o / out_stall_i    | out_byte_o, end_of_packet_o,
//          |           |                              | key_frame_o, first_of_unit_o
// cfg      | input     | cfg_valid_i / cfg_ready_o    | cfg_payload_limit_i[15:0]
//
// One byte per cycle in and out unless stalled; splits are decided on a 7-byte window.
// The first six bytes after reset fill the window and give no output beat.
// Each output beat is registered in the two-beat queue and then in the output register.
// in_stall_o rises only when the two-beat queue is full; it is decoded from the queue count.
// Reset clears the window and packet count, sets the unit-start flag and payload_limit to 65535.
`timescale 1ns / 1ps
`default_nettype none

module hevc_nal_packet_splitter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  out_byte_o,
  output      logic        end_of_packet_o,
  output      logic        key_frame_o,
  output      logic        first_of_unit_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [15:0] cfg_payload_limit_i
);
  import nps_pkg::*;

  logic      accept;
  logic      push;
  logic      full;
  logic      nonempty;
  logic      pop;
  nps_beat_t front_beat;
  nps_beat_t queue_beat;
  nps_beat_t out_beat;

  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;
  assign cfg_ready_o = 1'b1;

  nps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_payload_limit_i),
    .push_o      (push),
    .beat_o      (front_beat)
  );

  nps_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .beat_i     (front_beat),
    .full_o     (full),
    .nonempty_o (nonempty),
    .pop_i      (pop),
    .beat_o     (queue_beat)
  );

  nps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .nonempty_i  (nonempty),
    .beat_i      (queue_beat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .beat_o      (out_beat)
  );

  assign out_byte_o      = out_beat.out_byte;
  assign end_of_packet_o = out_beat.end_of_packet;
  assign key_frame_o     = out_beat.key_frame;
  assign first_of_unit_o = out_beat.first_of_unit;

endmodule

`default_nettype wire

// ----- rtl/nps_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nps_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              cfg_we_i,
  input  wire logic [15:0]       cfg_data_i,
  output      logic              push_o,
  output      nps_pkg::nps_beat_t beat_o
);
  import nps_pkg::*;

  logic [7:0]       line_q [WindowBytes];
  logic [7:0]       line_d [WindowBytes];
  logic [FillW-1:0] fill_q, fill_d;
  logic [5:0]       cur_type_q, cur_type_d;
  logic [15:0]      pcount_q, pcount_d;
  logic             usf_q, usf_d;
  logic [15:0]      limit_q;

  logic        code_seen;
  logic        split;
  logic        produce;
  logic        eop;
  logic [5:0]  new_type;
  logic [7:0]  type_bits;
  logic [16:0] count;
  logic [15:0] limit;

  always_comb begin
    for (int i = 0; i < WindowBytes - 1; i++) begin
      line_d[i] = line_q[i+1];
    end
    line_d[WindowBytes-1] = data_byte_i;
    fill_d = (fill_q < FillW'(WindowBytes)) ? fill_q + FillW'(1) : fill_q;

    code_seen = (fill_d >= FillW'(WindowBytes - 1)) &&
                (line_d[1] == ZeroByte) && (line_d[2] == ZeroByte) &&
                (line_d[3] == ZeroByte) && (line_d[4] == OneByte);
    type_bits = line_d[5] & NalTypeMask;
    new_type  = type_bits[6:1];
    split     = code_seen && ((cur_type_q == NalTypeSplit) || (new_type == NalTypeSplit));
    produce   = (fill_d == FillW'(WindowBytes));

    count = {1'b0, pcount_q} + 17'd1;
    limit = (limit_q == 16'd0) ? 16'd1 : limit_q;
    eop   = split || (count >= {1'b0, limit});

    beat_o.out_byte      = line_d[0];
    beat_o.end_of_packet = eop;
    beat_o.key_frame     = eop && is_key_type(cur_type_q);
    beat_o.first_of_unit = eop && usf_q;
    push_o               = accept_i && produce;

    cur_type_d = cur_type_q;
    pcount_d   = pcount_q;
    usf_d      = usf_q;
    if (produce) begin
      if (eop) begin
        pcount_d = 16'd0;
        usf_d    = 1'b0;
      end else begin
        pcount_d = count[15:0];
      end
    end
    if (code_seen) begin
      cur_type_d = new_type;
      if (split) begin
        usf_d    = 1'b1;
        pcount_d = 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WindowBytes; i++) begin
        line_q[i] <= ZeroByte;
      end
      fill_q     <= '0;
      cur_type_q <= '0;
      pcount_q   <= '0;
      usf_q      <= 1'b1;
      limit_q    <= 16'hFFFF;
    end else begin
      if (accept_i) begin
        for (int i = 0; i < WindowBytes; i++) begin
          line_q[i] <= line_d[i];
        end
        fill_q     <= fill_d;
        cur_type_q <= cur_type_d;
        pcount_q   <= pcount_d;
        usf_q      <= usf_d;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/nps_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nps_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire nps_pkg::nps_beat_t beat_i,
  output      logic               full_o,
  output      logic               nonempty_o,
  input  wire logic               pop_i,
  output      nps_pkg::nps_beat_t beat_o
);
  import nps_pkg::*;

  nps_beat_t         mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_q, rd_q;
  logic [QCountW-1:0] cnt_q;

  assign full_o     = (cnt_q == QCountW'(QueueDepth));
  assign nonempty_o = (cnt_q != '0);
  assign beat_o     = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCountW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCountW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/nps_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nps_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               nonempty_i,
  input  wire nps_pkg::nps_beat_t beat_i,
  output      logic               pop_o,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      nps_pkg::nps_beat_t beat_o
);
  import nps_pkg::*;

  logic      valid_q;
  nps_beat_t beat_q;

  // advance when the output register is empty or being drained
  assign pop_o       = nonempty_i && (!valid_q || !out_stall_i);
  assign out_valid_o = valid_q;
  assign beat_o      = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      beat_q <= beat_i;
    end
  end

endmodule

`default_nettype wire
